FILE: design/pqcw_pkg.sv
// ----------------------------------------------------------------------------
// pqcw_pkg
// Shared widths, pipeline depths and sideband types of the pose converter.
// ----------------------------------------------------------------------------
package pqcw_pkg;

    localparam int QW          = 32;                 // quaternion / rotation width
    localparam int TW          = 32;                 // translation width
    localparam int PW          = 40;                 // position width
    localparam int NW          = 64;                 // numerator / product width
    localparam int DW          = 63;                 // squared norm width
    localparam int QUO_W       = 33;                 // quotient bits, 2 int + 31 frac
    localparam int NUM_TERMS   = 9;
    localparam int PREP_STAGES = 4;
    localparam int DIV_STAGES  = QUO_W;
    localparam int POS_STAGES  = 4;
    localparam int LATENCY     = PREP_STAGES + DIV_STAGES + POS_STAGES;

    localparam logic signed [QW-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [QW-1:0] NEG_ONE_Q30 = -32'sh4000_0000;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [TW-1:0] t_t;
    typedef logic signed [PW-1:0] t_p;
    typedef logic [NW-1:0]        t_num;
    typedef logic [DW-1:0]        t_den;
    typedef logic [QUO_W-1:0]     t_quo;

    // Data that rides alongside the dividers.
    typedef struct packed {
        logic                 zero;
        logic [NUM_TERMS-1:0] neg;
        t_t                   tx;
        t_t                   ty;
        t_t                   tz;
    } t_side;

    function automatic logic is_diag(input int k);
        return (k == 0) || (k == 4) || (k == 8);
    endfunction

endpackage

FILE: design/pqcw_prep.sv
// ----------------------------------------------------------------------------
// pqcw_prep
// Scales the quaternion, forms its products, the squared norm and the nine
// numerator magnitudes with their signs. Four register stages.
// ----------------------------------------------------------------------------
module pqcw_prep
    import pqcw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_q    i_w,
    input  t_q    i_x,
    input  t_q    i_y,
    input  t_q    i_z,
    input  t_t    i_tx,
    input  t_t    i_ty,
    input  t_t    i_tz,
    output t_num  o_num [NUM_TERMS],
    output t_den  o_den,
    output t_side o_side
);

    // Stage 1: halving.
    t_q r_w, r_x, r_y, r_z;
    t_t r_t1 [3];
    logic w_big;

    assign w_big = (i_w >= ONE_Q30) || (i_w <= NEG_ONE_Q30) ||
                   (i_x >= ONE_Q30) || (i_x <= NEG_ONE_Q30) ||
                   (i_y >= ONE_Q30) || (i_y <= NEG_ONE_Q30) ||
                   (i_z >= ONE_Q30) || (i_z <= NEG_ONE_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w     <= w_big ? (i_w >>> 1) : i_w;
            r_x     <= w_big ? (i_x >>> 1) : i_x;
            r_y     <= w_big ? (i_y >>> 1) : i_y;
            r_z     <= w_big ? (i_z >>> 1) : i_z;
            r_t1[0] <= i_tx;
            r_t1[1] <= i_ty;
            r_t1[2] <= i_tz;
        end
    end

    // Stage 2: products.
    logic signed [NW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    t_t r_t2 [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= NW'(r_w * r_w);
            r_xx <= NW'(r_x * r_x);
            r_yy <= NW'(r_y * r_y);
            r_zz <= NW'(r_z * r_z);
            r_xy <= NW'(r_x * r_y);
            r_wz <= NW'(r_w * r_z);
            r_xz <= NW'(r_x * r_z);
            r_wy <= NW'(r_w * r_y);
            r_yz <= NW'(r_y * r_z);
            r_wx <= NW'(r_w * r_x);
            r_t2 <= r_t1;
        end
    end

    // Stage 3: sums.
    logic signed [NW-1:0] r_sum [NUM_TERMS];
    logic        [NW-1:0] r_n2;
    t_t r_t3 [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n2     <= r_ww + r_xx + r_yy + r_zz;
            r_sum[0] <= r_yy + r_zz;
            r_sum[1] <= r_xy - r_wz;
            r_sum[2] <= r_xz + r_wy;
            r_sum[3] <= r_xy + r_wz;
            r_sum[4] <= r_xx + r_zz;
            r_sum[5] <= r_yz - r_wx;
            r_sum[6] <= r_xz - r_wy;
            r_sum[7] <= r_yz + r_wx;
            r_sum[8] <= r_xx + r_yy;
            r_t3     <= r_t2;
        end
    end

    // Stage 4: doubled magnitudes and signs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                o_num[k]      <= (r_sum[k][NW-1] ? (-r_sum[k]) : r_sum[k]) << 1;
                o_side.neg[k] <= r_sum[k][NW-1];
            end
            o_den       <= r_n2[DW-1:0];
            o_side.zero <= (r_n2 == '0);
            o_side.tx   <= r_t3[0];
            o_side.ty   <= r_t3[1];
            o_side.tz   <= r_t3[2];
        end
    end

endmodule

FILE: design/pqcw_div.sv
// ----------------------------------------------------------------------------
// pqcw_div
// Pipelined restoring divider: floor(num * 2^31 / den), one quotient bit
// per stage. The quotient is below 2^33 since num never exceeds 2 * den.
// ----------------------------------------------------------------------------
module pqcw_div
    import pqcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_num i_num,
    input  t_den i_den,
    output t_quo o_quo
);

    t_num r_rem [DIV_STAGES];
    t_den r_den [DIV_STAGES];
    t_quo r_quo [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        t_num w_rem_in;
        t_den w_den_in;
        t_quo w_quo_in;
        t_num w_part;
        t_num w_div;
        logic w_bit;

        if (g == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
            assign w_part   = w_rem_in;
            // Top integer bit weighs twice the divisor.
            assign w_div    = {w_den_in, 1'b0};
        end else if (g == 1) begin : g_second
            assign w_rem_in = r_rem[g-1];
            assign w_den_in = r_den[g-1];
            assign w_quo_in = r_quo[g-1];
            assign w_part   = w_rem_in;
            assign w_div    = {1'b0, w_den_in};
        end else begin : g_frac
            assign w_rem_in = r_rem[g-1];
            assign w_den_in = r_den[g-1];
            assign w_quo_in = r_quo[g-1];
            assign w_part   = {w_rem_in[NW-2:0], 1'b0};
            assign w_div    = {1'b0, w_den_in};
        end

        assign w_bit = (w_part >= w_div);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_bit ? (w_part - w_div) : w_part;
                r_den[g] <= w_den_in;
                r_quo[g] <= {w_quo_in[QUO_W-2:0], w_bit};
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

FILE: design/pqcw_pos.sv
// ----------------------------------------------------------------------------
// pqcw_pos
// Rounds the ratios into rotation terms, applies the axis flip and forms the
// camera position. Four register stages, the last one the output register.
// ----------------------------------------------------------------------------
module pqcw_pos
    import pqcw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_quo  i_quo [NUM_TERMS],
    input  t_side i_side,
    output t_q    o_m   [NUM_TERMS],
    output t_p    o_pos [3]
);

    // Stage 1: rotation terms R[k], row-major.
    t_q r_rot1 [NUM_TERMS];
    t_t r_t1   [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                logic [QUO_W:0]        v_sum;
                logic signed [QUO_W:0] v_mag;
                logic signed [QUO_W:0] v_res;
                v_sum = {1'b0, i_quo[k]} + (QUO_W+1)'(1);
                v_mag = {2'b00, v_sum[QUO_W-1:1]};
                if (is_diag(k)) begin
                    v_res = (QUO_W+1)'(ONE_Q30) - v_mag;
                end else begin
                    v_res = i_side.neg[k] ? -v_mag : v_mag;
                end
                if (i_side.zero) begin
                    r_rot1[k] <= is_diag(k) ? ONE_Q30 : '0;
                end else begin
                    r_rot1[k] <= v_res[QW-1:0];
                end
            end
            r_t1[0] <= i_side.tx;
            r_t1[1] <= i_side.ty;
            r_t1[2] <= i_side.tz;
        end
    end

    // Stage 2: products R[j][i] * t[j].
    logic signed [NW-1:0] r_prod [NUM_TERMS];
    t_q r_rot2 [NUM_TERMS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_prod[k] <= NW'(r_rot1[k] * r_t1[k / 3]);
            end
            r_rot2 <= r_rot1;
        end
    end

    // Stage 3: column sums.
    logic signed [NW-1:0] r_sum [3];
    t_q r_rot3 [NUM_TERMS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= r_prod[i] + r_prod[3 + i] + r_prod[6 + i];
            end
            r_rot3 <= r_rot2;
        end
    end

    // Stage 4: negate, round to 16 fraction bits, and transpose with flip.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [NW-1:0] v_mag;
                logic [NW-1:0] v_rnd;
                v_mag = r_sum[i][NW-1] ? (-r_sum[i]) : r_sum[i];
                v_rnd = (v_mag + (NW'(1) << 29)) >> 30;
                o_pos[i]       <= r_sum[i][NW-1] ? v_rnd[PW-1:0] : (-v_rnd[PW-1:0]);
                o_m[3 * i]     <= r_rot3[i];
                o_m[3 * i + 1] <= -r_rot3[3 + i];
                o_m[3 * i + 2] <= -r_rot3[6 + i];
            end
        end
    end

endmodule

FILE: design/pose_quat_to_cam_to_world.sv
// ----------------------------------------------------------------------------
// pose_quat_to_cam_to_world
// World-to-camera quaternion and translation in, camera-to-world pose out.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while not held; each runs
// through four stages of scaling, products and sums, 33 stages of a pipelined
// divider (one quotient bit per stage, nine lanes in parallel) and four
// stages of rounding and position products. The whole pipeline holds while
// a finished result waits at the output, so nothing is lost or repeated.
module pose_quat_to_cam_to_world
    import pqcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_q   i_quat_w,
    input  t_q   i_quat_x,
    input  t_q   i_quat_y,
    input  t_q   i_quat_z,
    input  t_t   i_trans_x,
    input  t_t   i_trans_y,
    input  t_t   i_trans_z,
    output logic o_valid,
    input  logic i_ready,
    output t_q   o_m00,
    output t_q   o_m01,
    output t_q   o_m02,
    output t_q   o_m10,
    output t_q   o_m11,
    output t_q   o_m12,
    output t_q   o_m20,
    output t_q   o_m21,
    output t_q   o_m22,
    output t_p   o_pos_x,
    output t_p   o_pos_y,
    output t_p   o_pos_z
);

    logic  w_en;
    logic  r_vld  [LATENCY];
    t_side r_side [DIV_STAGES];
    t_num  w_num  [NUM_TERMS];
    t_den  w_den;
    t_side w_side;
    t_quo  w_quo  [NUM_TERMS];
    t_q    w_m    [NUM_TERMS];
    t_p    w_pos  [3];

    assign o_valid = r_vld[LATENCY-1];
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LATENCY; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < LATENCY; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    pqcw_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_w    (i_quat_w),
        .i_x    (i_quat_x),
        .i_y    (i_quat_y),
        .i_z    (i_quat_z),
        .i_tx   (i_trans_x),
        .i_ty   (i_trans_y),
        .i_tz   (i_trans_z),
        .o_num  (w_num),
        .o_den  (w_den),
        .o_side (w_side)
    );

    for (genvar k = 0; k < NUM_TERMS; k++) begin : g_div
        pqcw_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[k]),
            .i_den (w_den),
            .o_quo (w_quo[k])
        );
    end

    pqcw_pos u_pos (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_quo  (w_quo),
        .i_side (r_side[DIV_STAGES-1]),
        .o_m    (w_m),
        .o_pos  (w_pos)
    );

    assign o_m00   = w_m[0];
    assign o_m01   = w_m[1];
    assign o_m02   = w_m[2];
    assign o_m10   = w_m[3];
    assign o_m11   = w_m[4];
    assign o_m12   = w_m[5];
    assign o_m20   = w_m[6];
    assign o_m21   = w_m[7];
    assign o_m22   = w_m[8];
    assign o_pos_x = w_pos[0];
    assign o_pos_y = w_pos[1];
    assign o_pos_z = w_pos[2];

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the pose converter: each quaternion and translation request
// is predicted in the bench, and every result is checked field by field
// against the oldest prediction, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import pqcw_pkg::*;
();

    localparam longint ONE = longint'(1) << 30;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_q   i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    t_t   i_trans_x = '0, i_trans_y = '0, i_trans_z = '0;
    logic o_ready, o_valid;
    t_q   o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    t_p   o_pos_x, o_pos_y, o_pos_z;

    typedef struct {
        logic signed [PW-1:0] f[12];
    } t_pose;

    t_pose pose_q[$];
    int    errors = 0;
    int    send_gap_max = 12;
    int    recv_gap_max = 12;
    int    recv_wait = 0;

    pose_quat_to_cam_to_world u_top (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Rounded num/den in Q30, num >= 0, den > 0, half away from zero.
    function automatic longint rot_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] f, r;
        f = num / den;
        r = num % den;
        for (int i = 0; i < 31; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= den) begin
                r = r - den;
                f[0] = 1'b1;
            end
        end
        return longint'((f + 64'd1) >> 1);
    endfunction

    function automatic longint rot_sratio(longint num, logic [63:0] den);
        if (num < 0) return -rot_ratio(-num, den);
        return rot_ratio(num, den);
    endfunction

    function automatic longint halve_down(longint v);
        return (v >= 0) ? v / 2 : -((-v + 1) / 2);
    endfunction

    function automatic t_pose calc_cam_pose(t_q qw, t_q qx, t_q qy, t_q qz,
                                            t_t tx, t_t ty, t_t tz);
        longint w, x, y, z, s, q;
        longint r[9];
        longint t[3];
        logic [63:0] n2, mag;
        t_pose o;
        w = qw; x = qx; y = qy; z = qz;
        t[0] = tx; t[1] = ty; t[2] = tz;
        if (w >= ONE || w <= -ONE || x >= ONE || x <= -ONE ||
            y >= ONE || y <= -ONE || z >= ONE || z <= -ONE) begin
            w = halve_down(w); x = halve_down(x);
            y = halve_down(y); z = halve_down(z);
        end
        n2 = w*w + x*x + y*y + z*z;
        if (n2 == 0) begin
            foreach (r[k]) r[k] = 0;
            r[0] = ONE; r[4] = ONE; r[8] = ONE;
        end else begin
            r[0] = ONE - rot_ratio(2*(y*y + z*z), n2);
            r[1] = rot_sratio(2*(x*y - w*z), n2);
            r[2] = rot_sratio(2*(x*z + w*y), n2);
            r[3] = rot_sratio(2*(x*y + w*z), n2);
            r[4] = ONE - rot_ratio(2*(x*x + z*z), n2);
            r[5] = rot_sratio(2*(y*z - w*x), n2);
            r[6] = rot_sratio(2*(x*z - w*y), n2);
            r[7] = rot_sratio(2*(y*z + w*x), n2);
            r[8] = ONE - rot_ratio(2*(x*x + y*y), n2);
        end
        for (int i = 0; i < 3; i++) begin
            s = r[i]*t[0] + r[3+i]*t[1] + r[6+i]*t[2];
            mag = (s < 0) ? -s : s;
            q = longint'((mag + (64'd1 << 29)) >> 30);
            o.f[9+i] = 40'((s < 0) ? q : -q);
            // Rotation fields are 32-bit; sign-extend the wrapped value.
            o.f[3*i]   = 40'(t_q'(r[i]));
            o.f[3*i+1] = 40'(t_q'(-r[3+i]));
            o.f[3*i+2] = 40'(t_q'(-r[6+i]));
        end
        return o;
    endfunction

    task automatic send_pose(t_q qw, t_q qx, t_q qy, t_q qz, t_t tx, t_t ty, t_t tz);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_quat_w  <= qw; i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz;
        i_trans_x <= tx; i_trans_y <= ty; i_trans_z <= tz;
        do @(posedge i_clk); while (!o_ready);
        pose_q.insert(pose_q.size(), calc_cam_pose(qw, qx, qy, qz, tx, ty, tz));
    endtask

    // Receiver: random stall per result, checks at every accepted result.
    always @(posedge i_clk) begin
        t_pose exp_p;
        logic signed [PW-1:0] got[12];
        string names[12];
        names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22",
                  "pos_x", "pos_y", "pos_z"};
        got = '{40'(o_m00), 40'(o_m01), 40'(o_m02), 40'(o_m10), 40'(o_m11),
                40'(o_m12), 40'(o_m20), 40'(o_m21), 40'(o_m22),
                o_pos_x, o_pos_y, o_pos_z};
        if (i_rst_n && o_valid && i_ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                errors++;
            end else begin
                exp_p = pose_q.pop_front();
                for (int k = 0; k < 12; k++)
                    if (got[k] !== exp_p.f[k]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, names[k],
                                 exp_p.f[k], got[k]);
                        errors++;
                    end
            end
            recv_wait = $urandom_range(recv_gap_max, 0);
        end
        if (recv_wait > 0) begin
            recv_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic t_q rand_comp();
        case ($urandom_range(5, 0))
            0: return t_q'($urandom);
            1: return t_q'($urandom_range(2 * 32'h4000_0000 - 1, 0) - 32'h4000_0000);
            2: return t_q'($urandom_range(2047, 0) - 1024);
            3: return 32'sh3fff_ffff - t_q'($urandom_range(3, 0));
            4: return 32'sh4000_0000 + t_q'($urandom_range(3, 0));
            default: return t_q'($urandom_range(32'h4000_0000, 0) >> $urandom_range(30, 0));
        endcase
    endfunction

    function automatic t_t rand_trans();
        if ($urandom_range(3, 0) == 0) return t_t'($urandom);
        return t_t'($urandom_range(32'h0100_0000, 0)) - 32'sh0080_0000;
    endfunction

    task automatic test_extremes();
        t_q qv[4];
        qv = '{32'sh7fff_ffff, -32'sh8000_0000, 32'sh4000_0000, 32'sh3fff_ffff};
        foreach (qv[a])
            foreach (qv[b])
                send_pose(qv[a], qv[b], -qv[a], -qv[b],
                          32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff);
        send_pose(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                  -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    endtask

    task automatic test_special();
        // Zero quaternion falls back to identity; then unit axes and a tiny one.
        send_pose(0, 0, 0, 0, 32'sh0001_0000, -32'sh0002_0000, 32'sh7fff_ffff);
        send_pose(0, 0, 0, 0, -32'sh8000_0000, 0, 1);
        send_pose(32'sh4000_0000, 0, 0, 0, 32'sh0003_0000, 5, -7);
        send_pose(0, 32'sh4000_0000, 0, 0, 32'sh0003_0000, 5, -7);
        send_pose(0, 0, -32'sh4000_0000, 0, 32'sh0003_0000, 5, -7);
        send_pose(0, 0, 0, -32'sh3fff_ffff, 32'sh0003_0000, 5, -7);
        send_pose(1, -1, 1, 0, 32'sh1234_5678, -32'sh1234_5678, 0);
        send_pose(-1, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 300 == 0) begin
                send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 12;
                recv_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 12;
            end
            send_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      rand_trans(), rand_trans(), rand_trans());
        end
        send_gap_max = 12;
        recv_gap_max = 12;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_special();
        test_random(1880);
        i_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
